// File: sv/c3x3mb_pkg.sv
// shared constants and types of the 3x3 mirrored-border convolution core
package c3x3mb_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_COEF_BITS = 8;

    // register field widths
    localparam int WIDTH_REG_W = 11;
    localparam int ROW_W       = 12;
    localparam int COEF_REG_W  = 24;
    localparam int SHIFT_W     = 4;

    // apb port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RESULT_SHIFT = 3'd5;

    // register reset values
    localparam logic [WIDTH_REG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [ROW_W-1:0]       RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [COEF_REG_W-1:0]  RST_COEF_TOP     = 24'h0100FF;
    localparam logic [COEF_REG_W-1:0]  RST_COEF_MIDDLE  = 24'h0200FE;
    localparam logic [COEF_REG_W-1:0]  RST_COEF_BOTTOM  = 24'h0100FF;
    localparam logic [SHIFT_W-1:0]     RST_RESULT_SHIFT = 4'd0;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    // one window column, index 0 = oldest row
    typedef logic [2:0][PIXEL_BITS-1:0] col_t;
    // 3x3 taps, [kernel row][kernel column]
    typedef logic [2:0][2:0][PIXEL_BITS-1:0] taps_t;

    typedef struct packed {
        logic end_of_row;
        logic end_of_image;
    } tag_t;

endpackage

// File: sv/conv3x3_mirror_border_core.sv
// 3x3 convolution over an 8-bit pixel stream with mirrored (edge-replicated) border
//
//  channel   | ports          | payload
//  ----------+----------------+------------------------------------------------
//  pixels in | s_t*           | tdata[7:0] pixel_value, tuser[0] is_flush
//  result    | m_t*           | tdata[7:0] result_pixel, tlast end_of_row,
//            |                | tuser[0] end_of_image, tuser[1] was_clipped
//  config    | psel..pready   | six registers at byte address 4*i, 32-bit data
//
//  one item per clock sustained while the result side does not stall; a result
//  passes the line read, tap select, multiply, sum, magnitude and round/clamp steps
//  before it leaves the output register, through the registered line-store read
//  and the multiply/add pipeline
//  results lag the pixel stream by one row plus one pixel; flush items drain the
//  last row, a flush with nothing pending is taken and dropped
//  synchronous active-low reset clears counters and valids and loads the registers
//  with their reset values; line stores need no clearing pass
//  a stall on the result side backs up through the stages; empty stages keep
//  taking items while a result waits
module conv3x3_mirror_border_core
    import c3x3mb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int COEF_BITS = DEF_COEF_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel_value
    input  logic                  s_tuser,   // [0] is_flush
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] result_pixel
    output logic                  m_tlast,   // end_of_row
    output logic [1:0]            m_tuser    // [0] end_of_image, [1] was_clipped
);

    localparam int CW  = $clog2(MAX_WIDTH);          // column index
    localparam int WW  = CW + 1;                      // holds the width itself
    localparam int LW  = $clog2(MAX_WIDTH + 3);       // lag and pending counts
    localparam int PW  = COEF_BITS + PIXEL_BITS + 1;  // one product
    localparam int SW  = PW + 4;                      // sum of nine products
    localparam int CRW = 3 * COEF_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0] image_width_reg;
    logic [ROW_W-1:0]       image_height_reg;
    logic [COEF_REG_W-1:0]  coef_reg [3];   // top, middle, bottom
    logic [SHIFT_W-1:0]     result_shift_reg;

    logic [REG_IDX_W-1:0]   reg_idx;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            coef_reg[0]      <= RST_COEF_TOP;
            coef_reg[1]      <= RST_COEF_MIDDLE;
            coef_reg[2]      <= RST_COEF_BOTTOM;
            result_shift_reg <= RST_RESULT_SHIFT;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[ROW_W-1:0];
                REG_COEF_TOP:     coef_reg[0]      <= pwdata[COEF_REG_W-1:0];
                REG_COEF_MIDDLE:  coef_reg[1]      <= pwdata[COEF_REG_W-1:0];
                REG_COEF_BOTTOM:  coef_reg[2]      <= pwdata[COEF_REG_W-1:0];
                REG_RESULT_SHIFT: result_shift_reg <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            REG_COEF_TOP:     prdata = APB_DATA_W'(coef_reg[0]);
            REG_COEF_MIDDLE:  prdata = APB_DATA_W'(coef_reg[1]);
            REG_COEF_BOTTOM:  prdata = APB_DATA_W'(coef_reg[2]);
            REG_RESULT_SHIFT: prdata = APB_DATA_W'(result_shift_reg);
            default:          prdata = '0;
        endcase
    end

    // effective image size: width clamped to 1..MAX_WIDTH, height 0 taken as 1
    logic [WW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;

    always_comb begin
        if (image_width_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(image_width_reg);
        end
        eff_h = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;
    end

    // ------------------------------------------------------------------
    // stage handshakes: each stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic emit1_reg;
    logic rdy_out, rdy5, rdy4, rdy3, rdy2, adv1;

    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy5     = !v5_reg || rdy_out;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    // items that give no result leave stage 1 without needing stage 2
    assign adv1     = v1_reg && (!emit1_reg || rdy2);
    assign s_tready = !v1_reg || adv1;
    assign m_tvalid = m_valid_reg;

    // ------------------------------------------------------------------
    // position tracking, done when the item is taken
    // ------------------------------------------------------------------
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [LW-1:0]    lag_reg, lag_next;       // items held in the window/line lag
    logic [LW-1:0]    pend_reg, pend_next;     // pixels still owed a result

    logic             take_item;
    logic [LW:0]      lag_inc;
    logic [LW-1:0]    pend_inc;
    logic             emit;
    logic             in_col_wrap, out_col_last, out_row_last;

    always_comb begin
        // a flush with nothing pending is swallowed
        take_item    = s_tvalid && s_tready && !(s_tuser && pend_reg == '0);
        lag_inc      = (LW+1)'(lag_reg) + (LW+1)'(1);
        pend_inc     = pend_reg + LW'(!s_tuser);
        emit         = (lag_inc >= (LW+1)'(eff_w) + (LW+1)'(2)) && (pend_inc != '0);
        in_col_wrap  = (WW'(in_col_reg) + WW'(1)) >= eff_w;
        out_col_last = (WW'(out_col_reg) + WW'(1)) >= eff_w;
        out_row_last = ((ROW_W+1)'(out_row_reg) + (ROW_W+1)'(1)) >= (ROW_W+1)'(eff_h);

        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lag_next     = lag_reg;
        pend_next    = pend_reg;

        if (take_item) begin
            in_col_next = in_col_wrap ? '0 : in_col_reg + CW'(1);
            lag_next    = lag_inc[LW-1:0];
            pend_next   = pend_inc;
            if (emit) begin
                lag_next     = LW'(lag_inc - (LW+1)'(1));
                pend_next    = pend_inc - LW'(1);
                out_col_next = out_col_last ? '0 : out_col_reg + CW'(1);
                if (out_col_last) begin
                    out_row_next = out_row_last ? '0 : out_row_reg + ROW_W'(1);
                end
                // flush that drains the last pending pixel restarts the image
                if (s_tuser && pend_inc == LW'(1)) begin
                    in_col_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    lag_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
            pend_reg    <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lag_reg     <= lag_next;
            pend_reg    <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: item plus line-store read, both rows in one word {upper, lower}
    // ------------------------------------------------------------------
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] line_q_reg;
    logic [2*PIXEL_BITS-1:0] fwd_data_reg;
    logic                    fwd_reg;
    logic [2*PIXEL_BITS-1:0] line_wdata;

    pix_t          px1_reg;
    logic [CW-1:0] addr1_reg;
    logic          first_in1_reg;
    logic          first_col1_reg, last_col1_reg, first_row1_reg, last_row1_reg;

    pix_t upper_old, lower_old;

    always_comb begin
        // same-edge write to the address just read comes through the bypass
        {upper_old, lower_old} = fwd_reg ? fwd_data_reg : line_q_reg;
        // upper row takes the lower row, lower row takes the new pixel
        line_wdata = {lower_old, px1_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            line_mem[addr1_reg] <= line_wdata;
        end
        if (s_tready) begin
            line_q_reg   <= line_mem[in_col_reg];
            fwd_data_reg <= line_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            emit1_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end else if (s_tready) begin
            v1_reg    <= take_item;
            emit1_reg <= emit;
            fwd_reg   <= adv1 && (addr1_reg == in_col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            px1_reg        <= s_tuser ? '0 : s_tdata;
            addr1_reg      <= in_col_reg;
            first_in1_reg  <= (in_col_reg == '0);
            first_col1_reg <= (out_col_reg == '0);
            last_col1_reg  <= out_col_last;
            first_row1_reg <= (out_row_reg == '0);
            last_row1_reg  <= out_row_last;
        end
    end

    // window of three columns, 0 = leftmost
    col_t win0_reg, win1_reg, win2_reg;
    col_t new_col;

    always_comb begin
        new_col[0] = upper_old;
        new_col[1] = lower_old;
        new_col[2] = px1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            win0_reg <= win1_reg;
            win1_reg <= win2_reg;
            win2_reg <= new_col;
        end
    end

    // tap selection with border replication
    col_t        c0, c1, c2;
    logic [1:0]  top_idx, bot_idx;
    taps_t       taps_next;

    always_comb begin
        // on the first input column the window's right column is the previous
        // row's last pixel, which also stands in for the missing right neighbor
        c0 = win1_reg;
        c1 = win2_reg;
        c2 = first_in1_reg ? win2_reg : new_col;
        if (first_col1_reg) begin
            c0 = c1;
        end
        if (last_col1_reg) begin
            c2 = c1;
        end
        top_idx = first_row1_reg ? 2'd1 : 2'd0;
        bot_idx = last_row1_reg  ? 2'd1 : 2'd2;

        taps_next[0][0] = c0[top_idx];
        taps_next[0][1] = c1[top_idx];
        taps_next[0][2] = c2[top_idx];
        taps_next[1][0] = c0[1];
        taps_next[1][1] = c1[1];
        taps_next[1][2] = c2[1];
        taps_next[2][0] = c0[bot_idx];
        taps_next[2][1] = c1[bot_idx];
        taps_next[2][2] = c2[bot_idx];
    end

    // ------------------------------------------------------------------
    // stage 2: registered taps
    // ------------------------------------------------------------------
    taps_t taps2_reg;
    tag_t  tag2_reg, tag3_reg, tag4_reg, tag5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg && emit1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            taps2_reg             <= taps_next;
            tag2_reg.end_of_row   <= last_col1_reg;
            tag2_reg.end_of_image <= last_col1_reg && last_row1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: nine signed products
    // ------------------------------------------------------------------
    logic [CRW+COEF_REG_W-1:0]  coef_ext [3];
    logic signed [COEF_BITS-1:0] coef_w [3][3];
    logic signed [PW-1:0]        prod_reg [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef_ext[r] = {CRW'(0), coef_reg[r]};
            for (int k = 0; k < 3; k++) begin
                coef_w[r][k] = coef_ext[r][k*COEF_BITS +: COEF_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[r][k] <= coef_w[r][k] * $signed({1'b0, taps2_reg[r][k]});
                end
            end
            tag3_reg <= tag2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sum
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_next, sum4_reg;

    always_comb begin
        sum_next = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                sum_next = sum_next + SW'(prod_reg[r][k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            sum4_reg <= sum_next;
            tag4_reg <= tag3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: sign and magnitude; the output register rounds half away from zero
    // ------------------------------------------------------------------
    logic          neg5_reg;
    logic [SW-1:0] mag5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (rdy5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            neg5_reg <= sum4_reg[SW-1];
            mag5_reg <= sum4_reg[SW-1] ? $unsigned(-sum4_reg) : $unsigned(sum4_reg);
            tag5_reg <= tag4_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register: round, shift, clamp
    // ------------------------------------------------------------------
    logic [SW:0] half, rounded;
    logic        over, clip;
    pix_t        res;

    always_comb begin
        half    = (result_shift_reg == '0) ? '0
                : ((SW+1)'(1) << (result_shift_reg - SHIFT_W'(1)));
        rounded = ({1'b0, mag5_reg} + half) >> result_shift_reg;
        over    = rounded > (SW+1)'(255);
        // a negative sum that rounds to zero is a plain zero, not clipped
        clip    = neg5_reg ? (rounded != '0) : over;
        if (neg5_reg) begin
            res = '0;
        end else if (over) begin
            res = '1;
        end else begin
            res = rounded[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            m_tdata <= res;
            m_tlast <= tag5_reg.end_of_row;
            m_tuser <= {clip, tag5_reg.end_of_image};
        end
    end

endmodule
